@@ sv/rgbapm_pkg.sv @@
`default_nettype none

package rgbapm_pkg;

   localparam int PIX_W          = 8;
   localparam int NUM_W          = 2 * PIX_W;
   localparam int BITS_PER_STAGE = 2;
   localparam int DIV_STAGES     = PIX_W / BITS_PER_STAGE;
   localparam int NUM_STAGES     = DIV_STAGES + 1;

   localparam logic MODE_PREMUL   = 1'b0;
   localparam logic MODE_UNPREMUL = 1'b1;

   localparam logic [PIX_W-1:0] FULL_SCALE   = 8'd255;
   localparam logic [PIX_W-2:0] ROUND_PREMUL = 7'd127;

   typedef logic [PIX_W-1:0] pix_type;

   typedef struct packed {
      logic [NUM_STAGES-1:0] load;
   } stage_ctl_type;

endpackage

`default_nettype wire

@@ sv/rgbapm_req_if.sv @@
`default_nettype none

interface rgbapm_req_if;
   logic                 valid;
   logic                 ready;
   logic                 mode;
   rgbapm_pkg::pix_type  red_in;
   rgbapm_pkg::pix_type  green_in;
   rgbapm_pkg::pix_type  blue_in;
   rgbapm_pkg::pix_type  alpha_in;

   modport source (output valid, mode, red_in, green_in, blue_in, alpha_in, input ready);
   modport sink   (input valid, mode, red_in, green_in, blue_in, alpha_in, output ready);
endinterface

`default_nettype wire

@@ sv/rgbapm_rsp_if.sv @@
`default_nettype none

interface rgbapm_rsp_if;
   logic                 valid;
   logic                 ready;
   rgbapm_pkg::pix_type  red_out;
   rgbapm_pkg::pix_type  green_out;
   rgbapm_pkg::pix_type  blue_out;
   rgbapm_pkg::pix_type  alpha_out;

   modport source (output valid, red_out, green_out, blue_out, alpha_out, input ready);
   modport sink   (input valid, red_out, green_out, blue_out, alpha_out, output ready);
endinterface

`default_nettype wire

@@ sv/rgbapm_lane.sv @@
`default_nettype none

module rgbapm_lane (
   input  wire logic                      clock,
   input  wire rgbapm_pkg::stage_ctl_type ctl,
   input  wire logic                      mode,
   input  wire rgbapm_pkg::pix_type       color,
   input  wire rgbapm_pkg::pix_type       alpha,
   output      rgbapm_pkg::pix_type       result
);

   localparam int PW    = rgbapm_pkg::PIX_W;
   localparam int NW    = rgbapm_pkg::NUM_W;
   localparam int BPS   = rgbapm_pkg::BITS_PER_STAGE;
   localparam int STEPS = rgbapm_pkg::DIV_STAGES;

   logic [NW-1:0] rem_ff [STEPS];
   logic [NW-1:0] rem_in [STEPS];
   logic [PW-1:0] div_ff [STEPS];
   logic [PW-1:0] div_in [STEPS];
   logic [PW-1:0] quo_ff [STEPS];
   logic [PW-1:0] quo_in [STEPS];

   // numerator and divisor, then restoring division two quotient bits a stage
   always_comb begin
      logic [PW-1:0] clamped;
      logic [PW-1:0] mul_a;
      logic [PW-1:0] mul_b;
      logic [PW-2:0] bias;
      logic [NW-1:0] r;
      logic [NW-1:0] sh;
      logic [PW-1:0] q;
      logic [2:0]    k;

      clamped = (color < alpha) ? color : alpha;
      if (mode == rgbapm_pkg::MODE_UNPREMUL) begin
         mul_a = clamped;
         mul_b = rgbapm_pkg::FULL_SCALE;
         bias  = alpha[PW-1:1];
         div_in[0] = alpha;
      end else begin
         mul_a = color;
         mul_b = alpha;
         bias  = rgbapm_pkg::ROUND_PREMUL;
         div_in[0] = rgbapm_pkg::FULL_SCALE;
      end
      rem_in[0] = NW'(mul_a) * NW'(mul_b) + NW'(bias);

      for (int s = 0; s < STEPS; s++) begin
         r = rem_ff[s];
         q = (s == 0) ? '0 : quo_ff[(s == 0) ? 0 : s - 1];
         for (int j = 0; j < BPS; j++) begin
            k  = 3'(PW - 1 - BPS * s - j);
            sh = NW'(div_ff[s]) << k;
            if (r >= sh) begin
               r    = r - sh;
               q[k] = 1'b1;
            end
         end
         quo_in[s] = q;
         if (s + 1 < STEPS) begin
            rem_in[(s + 1 < STEPS) ? s + 1 : 0] = r;
            div_in[(s + 1 < STEPS) ? s + 1 : 0] = div_ff[s];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load[0]) begin
         rem_ff[0] <= rem_in[0];
         div_ff[0] <= div_in[0];
      end
      for (int s = 0; s < STEPS; s++) begin
         if (ctl.load[s + 1]) begin
            quo_ff[s] <= quo_in[s];
            if (s + 1 < STEPS) begin
               rem_ff[(s + 1 < STEPS) ? s + 1 : 0] <= rem_in[(s + 1 < STEPS) ? s + 1 : 0];
               div_ff[(s + 1 < STEPS) ? s + 1 : 0] <= div_in[(s + 1 < STEPS) ? s + 1 : 0];
            end
         end
      end
   end

   assign result = quo_ff[STEPS-1];

endmodule

`default_nettype wire

@@ sv/rgba_alpha_premultiply_converter.sv @@
// Converts one RGBA8 pixel a clock, unless rsp stalls, between straight and premultiplied
// alpha. With mode low each color becomes (c*a+127)/255, with mode high it becomes
// (min(c,a)*255+a/2)/a, and a zero alpha gives black when unpremultiplying. Alpha passes
// through. The block takes a new beat every cycle unless rsp backpressure fills the pipe
// and holds up to five beats in flight: one multiply stage, then four restoring division
// stages that each resolve two quotient bits. Backpressure on rsp stalls only the stages
// that are full, so bubbles are squeezed out before req.ready drops.
`default_nettype none

module rgba_alpha_premultiply_converter (
   input wire logic  clock,
   input wire logic  reset,
   rgbapm_req_if.sink   req,
   rgbapm_rsp_if.source rsp
);

   localparam int NST = rgbapm_pkg::NUM_STAGES;

   logic                      valid_ff [NST];
   rgbapm_pkg::pix_type       alpha_ff [NST];
   logic                      zero_ff  [NST];
   logic [NST:0]              rdy;
   rgbapm_pkg::stage_ctl_type ctl;
   rgbapm_pkg::pix_type       red_q;
   rgbapm_pkg::pix_type       green_q;
   rgbapm_pkg::pix_type       blue_q;

   // a stage loads when it is empty or its contents move on
   always_comb begin
      rdy[NST] = rsp.ready;
      for (int k = NST - 1; k >= 0; k--) begin
         rdy[k] = !valid_ff[k] || rdy[k + 1];
      end
      ctl.load = rdy[NST-1:0];
   end

   assign req.ready = rdy[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NST; k++) begin
            valid_ff[k] <= 1'b0;
         end
      end else begin
         if (ctl.load[0]) begin
            valid_ff[0] <= req.valid;
         end
         for (int k = 1; k < NST; k++) begin
            if (ctl.load[k]) begin
               valid_ff[k] <= valid_ff[k - 1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load[0]) begin
         alpha_ff[0] <= req.alpha_in;
         zero_ff[0]  <= (req.mode == rgbapm_pkg::MODE_UNPREMUL) && (req.alpha_in == '0);
      end
      for (int k = 1; k < NST; k++) begin
         if (ctl.load[k]) begin
            alpha_ff[k] <= alpha_ff[k - 1];
            zero_ff[k]  <= zero_ff[k - 1];
         end
      end
   end

   rgbapm_lane u_red (
      .clock  (clock),
      .ctl    (ctl),
      .mode   (req.mode),
      .color  (req.red_in),
      .alpha  (req.alpha_in),
      .result (red_q)
   );

   rgbapm_lane u_green (
      .clock  (clock),
      .ctl    (ctl),
      .mode   (req.mode),
      .color  (req.green_in),
      .alpha  (req.alpha_in),
      .result (green_q)
   );

   rgbapm_lane u_blue (
      .clock  (clock),
      .ctl    (ctl),
      .mode   (req.mode),
      .color  (req.blue_in),
      .alpha  (req.alpha_in),
      .result (blue_q)
   );

   // zero alpha while unpremultiplying gives black
   assign rsp.valid     = valid_ff[NST-1];
   assign rsp.alpha_out = alpha_ff[NST-1];
   assign rsp.red_out   = zero_ff[NST-1] ? '0 : red_q;
   assign rsp.green_out = zero_ff[NST-1] ? '0 : green_q;
   assign rsp.blue_out  = zero_ff[NST-1] ? '0 : blue_q;

   a_full_when_blocked: assert property (@(posedge clock) disable iff (reset)
      !req.ready |-> (valid_ff[0] && valid_ff[NST-1]))
      else $error("req blocked while pipeline has room");

   a_beat_enters: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready) |=> valid_ff[0])
      else $error("accepted beat missing from first stage");

   a_mid_stage_holds: assert property (@(posedge clock) disable iff (reset)
      (valid_ff[1] && !rdy[2]) |=> (valid_ff[1] && $stable(alpha_ff[1])))
      else $error("stalled middle stage lost its beat");

endmodule

`default_nettype wire

@@ dv/tb_rgba_alpha_premultiply_converter.sv @@
`default_nettype none

module tb_rgba_alpha_premultiply_converter;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RESET_CYCLES    = 12;
   localparam int RANDOM_PIXELS   = 1230;
   localparam int STEADY_FIRST    = 400;
   localparam int STEADY_LAST     = 650;
   localparam int DRAIN_AT        = 800;
   localparam int IDLE_PERCENT    = 11;
   localparam int SETTLE_CYCLES   = 16;
   localparam int STALL_LIMIT     = 2000;
   localparam int NUM_ROWS        = 20;

   localparam logic MODE_PREMUL   = rgbapm_pkg::MODE_PREMUL;
   localparam logic MODE_UNPREMUL = rgbapm_pkg::MODE_UNPREMUL;

   typedef struct packed {
      logic                mode;
      rgbapm_pkg::pix_type red;
      rgbapm_pkg::pix_type green;
      rgbapm_pkg::pix_type blue;
      rgbapm_pkg::pix_type alpha;
   } rgba_beat_type;

   typedef struct packed {
      rgbapm_pkg::pix_type red;
      rgbapm_pkg::pix_type green;
      rgbapm_pkg::pix_type blue;
      rgbapm_pkg::pix_type alpha;
   } pixel_type;

   typedef struct packed {
      rgba_beat_type       stim;
      logic                typed;
      rgbapm_pkg::pix_type red;
      rgbapm_pkg::pix_type green;
      rgbapm_pkg::pix_type blue;
   } sample_row_type;

   // rows with typed set carry their own expected colors, the rest use the predictor
   localparam sample_row_type DIRECTED_ROWS [NUM_ROWS] = '{
      '{'{MODE_PREMUL,   8'd255, 8'd128, 8'd0,   8'd255}, 1'b1, 8'd255, 8'd128, 8'd0},
      '{'{MODE_PREMUL,   8'd255, 8'd255, 8'd255, 8'd0},   1'b1, 8'd0,   8'd0,   8'd0},
      '{'{MODE_PREMUL,   8'd255, 8'd255, 8'd255, 8'd128}, 1'b1, 8'd128, 8'd128, 8'd128},
      '{'{MODE_PREMUL,   8'd0,   8'd0,   8'd0,   8'd200}, 1'b1, 8'd0,   8'd0,   8'd0},
      '{'{MODE_PREMUL,   8'd255, 8'd0,   8'd255, 8'd1},   1'b1, 8'd1,   8'd0,   8'd1},
      '{'{MODE_PREMUL,   8'd1,   8'd254, 8'd127, 8'd254}, 1'b0, 8'd0,   8'd0,   8'd0},
      '{'{MODE_PREMUL,   8'd100, 8'd150, 8'd200, 8'd77},  1'b0, 8'd0,   8'd0,   8'd0},
      '{'{MODE_UNPREMUL, 8'd255, 8'd17,  8'd0,   8'd0},   1'b1, 8'd0,   8'd0,   8'd0},
      '{'{MODE_UNPREMUL, 8'd255, 8'd1,   8'd0,   8'd255}, 1'b1, 8'd255, 8'd1,   8'd0},
      '{'{MODE_UNPREMUL, 8'd200, 8'd255, 8'd100, 8'd100}, 1'b1, 8'd255, 8'd255, 8'd255},
      '{'{MODE_UNPREMUL, 8'd1,   8'd0,   8'd1,   8'd1},   1'b1, 8'd255, 8'd0,   8'd255},
      '{'{MODE_UNPREMUL, 8'd0,   8'd0,   8'd0,   8'd1},   1'b1, 8'd0,   8'd0,   8'd0},
      '{'{MODE_UNPREMUL, 8'd0,   8'd127, 8'd128, 8'd128}, 1'b0, 8'd0,   8'd0,   8'd0},
      '{'{MODE_UNPREMUL, 8'd64,  8'd32,  8'd16,  8'd128}, 1'b0, 8'd0,   8'd0,   8'd0},
      '{'{MODE_UNPREMUL, 8'd254, 8'd253, 8'd1,   8'd254}, 1'b0, 8'd0,   8'd0,   8'd0},
      '{'{MODE_UNPREMUL, 8'd255, 8'd255, 8'd255, 8'd255}, 1'b1, 8'd255, 8'd255, 8'd255},
      '{'{MODE_PREMUL,   8'd170, 8'd85,  8'd51,  8'd170}, 1'b0, 8'd0,   8'd0,   8'd0},
      '{'{MODE_UNPREMUL, 8'd0,   8'd0,   8'd0,   8'd0},   1'b1, 8'd0,   8'd0,   8'd0},
      '{'{MODE_PREMUL,   8'd255, 8'd255, 8'd255, 8'd255}, 1'b1, 8'd255, 8'd255, 8'd255},
      '{'{MODE_UNPREMUL, 8'd3,   8'd2,   8'd1,   8'd2},   1'b0, 8'd0,   8'd0,   8'd0}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   rgbapm_req_if req_bus ();
   rgbapm_rsp_if rsp_bus ();

   rgba_alpha_premultiply_converter DUT (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus)
   );

   pixel_type pending_pixels [$];
   int        mismatch_count = 0;
   int        stall_cycles   = 0;
   bit        steady_phase   = 1'b0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic rgbapm_pkg::pix_type convert_channel(logic mode,
                                                           rgbapm_pkg::pix_type color,
                                                           rgbapm_pkg::pix_type alpha);
      int unsigned c;
      int unsigned a;
      c = color;
      a = alpha;
      if (mode == MODE_PREMUL) begin
         return rgbapm_pkg::pix_type'((c * a + rgbapm_pkg::ROUND_PREMUL)
                                      / rgbapm_pkg::FULL_SCALE);
      end
      if (a == 0) begin
         return '0;
      end
      if (c > a) begin
         c = a;
      end
      return rgbapm_pkg::pix_type'((c * rgbapm_pkg::FULL_SCALE + a / 2) / a);
   endfunction

   function automatic pixel_type convert_pixel(rgba_beat_type px);
      pixel_type res;
      res.red   = convert_channel(px.mode, px.red, px.alpha);
      res.green = convert_channel(px.mode, px.green, px.alpha);
      res.blue  = convert_channel(px.mode, px.blue, px.alpha);
      res.alpha = px.alpha;
      return res;
   endfunction

   function automatic rgba_beat_type random_pixel();
      rgba_beat_type px;
      int unsigned   pick;
      pick     = $urandom_range(0, 99);
      px.mode  = $urandom_range(0, 1) ? MODE_UNPREMUL : MODE_PREMUL;
      px.alpha = rgbapm_pkg::pix_type'($urandom_range(0, 255));
      if (pick < 8) begin
         px.alpha = 8'd0;
      end else if (pick < 16) begin
         px.alpha = 8'd255;
      end else if (pick < 20) begin
         px.alpha = 8'd1;
      end
      px.red   = rgbapm_pkg::pix_type'($urandom_range(0, 255));
      px.green = rgbapm_pkg::pix_type'($urandom_range(0, 255));
      px.blue  = rgbapm_pkg::pix_type'($urandom_range(0, 255));
      // mostly valid premultiplied input, where no color exceeds alpha
      if (px.mode == MODE_UNPREMUL && $urandom_range(0, 99) < 80) begin
         px.red   = rgbapm_pkg::pix_type'($urandom_range(0, px.alpha));
         px.green = rgbapm_pkg::pix_type'($urandom_range(0, px.alpha));
         px.blue  = rgbapm_pkg::pix_type'($urandom_range(0, px.alpha));
      end
      return px;
   endfunction

   task automatic send_pixel(input rgba_beat_type px, input pixel_type expected);
      while (!steady_phase && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.mode     <= px.mode;
      req_bus.red_in   <= px.red;
      req_bus.green_in <= px.green;
      req_bus.blue_in  <= px.blue;
      req_bus.alpha_in <= px.alpha;
      do @(posedge clock); while (!req_bus.ready);
      pending_pixels.push_back(expected);
   endtask

   task automatic check_field(input string name, input rgbapm_pkg::pix_type exp,
                              input rgbapm_pkg::pix_type got);
      if (exp !== got) begin
         mismatch_count++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp, got);
      end
   endtask

   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_bus.ready <= !reset && (steady_phase || $urandom_range(0, 99) >= IDLE_PERCENT);
      end
   end

   always @(posedge clock) begin
      pixel_type exp;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_pixels.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected beat, expected none, actual %0d %0d %0d %0d", $time,
                     rsp_bus.red_out, rsp_bus.green_out, rsp_bus.blue_out, rsp_bus.alpha_out);
         end else begin
            exp = pending_pixels.pop_front();
            check_field("red_out",   exp.red,   rsp_bus.red_out);
            check_field("green_out", exp.green, rsp_bus.green_out);
            check_field("blue_out",  exp.blue,  rsp_bus.blue_out);
            check_field("alpha_out", exp.alpha, rsp_bus.alpha_out);
         end
      end
   end

   // stall watchdog
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      rgba_beat_type px;
      pixel_type     expected;
      req_bus.valid    <= 1'b0;
      req_bus.mode     <= MODE_PREMUL;
      req_bus.red_in   <= '0;
      req_bus.green_in <= '0;
      req_bus.blue_in  <= '0;
      req_bus.alpha_in <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED_ROWS[i]) begin
         px = DIRECTED_ROWS[i].stim;
         if (DIRECTED_ROWS[i].typed) begin
            expected = '{DIRECTED_ROWS[i].red, DIRECTED_ROWS[i].green,
                         DIRECTED_ROWS[i].blue, px.alpha};
         end else begin
            expected = convert_pixel(px);
         end
         send_pixel(px, expected);
      end

      for (int n = 0; n < RANDOM_PIXELS; n++) begin
         steady_phase = (n >= STEADY_FIRST && n < STEADY_LAST);
         if (n == DRAIN_AT) begin
            // hold off until the pipe is empty
            req_bus.valid <= 1'b0;
            do @(posedge clock); while (pending_pixels.size() != 0);
         end
         px = random_pixel();
         send_pixel(px, convert_pixel(px));
      end
      steady_phase = 1'b0;

      req_bus.valid <= 1'b0;
      do @(posedge clock); while (pending_pixels.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && pending_pixels.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire
